/* rtl/alid_pkg.sv */
// Shared types and codes for the array list insert/delete unit.
package alid_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FINISH
  } state_e;

  localparam int unsigned PosWidth = 9;
  localparam int unsigned ValWidth = 32;
  localparam int unsigned LenWidth = 9;

  typedef struct packed {
    action_e                      action;
    logic [PosWidth-1:0]          position;
    logic signed [ValWidth-1:0]   new_value;
  } in_t;

  typedef struct packed {
    status_e                      status;
    logic signed [ValWidth-1:0]   read_value;
    logic [LenWidth-1:0]          list_length;
    logic                         is_empty;
  } out_t;

endpackage

/* rtl/alid_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module alid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/array_list_insert_delete_unit.sv */
// Array list unit: bounded ordered list with insert, delete, read and clear.
// Insert/delete shift the entries between the given position and the list end;
//   read fetches one entry; clear and refused actions go straight to the result.
//   One entry moves per cycle through the single read and single write port of the entry RAM.
// Items: one at a time; a new item is not taken until the last result is staged.
// Reset: length and control clear at once; entry RAM is not cleared (entries
//   are only read after being written).
module array_list_insert_delete_unit #(
  parameter int unsigned CAPACITY   = 256,  // entries, 2 or more
  parameter int unsigned ELEM_WIDTH = 32    // stored bits per entry, 1..32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  alid_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output alid_pkg::out_t out_data_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > alid_pkg::PosWidth) ? CW : alid_pkg::PosWidth;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  alid_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;      // list length after current action
  logic              reading_q, reading_d;  // reads of the shift still to issue
  logic              rvalid_q, rvalid_d;    // RAM read data arrives this cycle
  logic              out_valid_q, out_valid_d;

  alid_pkg::action_e act_q, act_d;
  alid_pkg::status_e status_q, status_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [ELEM_WIDTH-1:0] val_q, val_d;
  logic [alid_pkg::ValWidth-1:0] rd_q, rd_d;
  logic [AW-1:0]     ptr_q, ptr_d;          // next read address
  logic [AW-1:0]     last_q, last_d;        // final read address
  logic [AW-1:0]     raddr_q, raddr_d;      // address of the read in flight
  alid_pkg::out_t    out_q, out_d;

  // RAM port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  // Compare helpers
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CW-1:0]   cnt_m1;

  assign pos_ext = CMPW'(in_data_i.position);
  assign cnt_ext = CMPW'(count_q);
  assign cnt_m1  = count_q - CW'(1);

  alid_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control: accept, shift loop, result staging
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    reading_d   = 1'b0;
    rvalid_d    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    act_d       = act_q;
    status_d    = status_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rd_d        = rd_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    raddr_d     = raddr_q;
    out_d       = out_q;

    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = val_q;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    in_ready_o  = 1'b0;

    unique case (state_q)
      alid_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d    = in_data_i.action;
          pos_d    = pos_ext[AW-1:0];
          val_d    = ELEM_WIDTH'($unsigned(in_data_i.new_value));
          rd_d     = '0;
          status_d = alid_pkg::STATUS_OK;
          state_d  = alid_pkg::S_FINISH;
          unique case (in_data_i.action)
            alid_pkg::ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = alid_pkg::STATUS_RANGE;
              end else if (count_q >= CW'(CAPACITY)) begin
                status_d = alid_pkg::STATUS_FULL;
              end else begin
                // shift [pos, count-1] up by one, top entry first
                count_d   = count_q + CW'(1);
                reading_d = (pos_ext != cnt_ext);
                ptr_d     = cnt_m1[AW-1:0];
                last_d    = pos_ext[AW-1:0];
                state_d   = alid_pkg::S_SHIFT;
              end
            end
            alid_pkg::ACT_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = alid_pkg::STATUS_RANGE;
              end else begin
                // read pos for the result, then move [pos+1, count-1] down
                count_d   = cnt_m1;
                reading_d = 1'b1;
                ptr_d     = pos_ext[AW-1:0];
                last_d    = cnt_m1[AW-1:0];
                state_d   = alid_pkg::S_SHIFT;
              end
            end
            alid_pkg::ACT_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_d = alid_pkg::STATUS_RANGE;
              end else begin
                reading_d = 1'b1;
                ptr_d     = pos_ext[AW-1:0];
                last_d    = pos_ext[AW-1:0];
                state_d   = alid_pkg::S_SHIFT;
              end
            end
            alid_pkg::ACT_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end

      alid_pkg::S_SHIFT: begin
        // issue side
        ram_re    = reading_q;
        ram_raddr = ptr_q;
        rvalid_d  = reading_q;
        raddr_d   = ptr_q;
        if (reading_q) begin
          reading_d = (ptr_q != last_q);
          ptr_d     = (act_q == alid_pkg::ACT_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
        end
        // write-back side: data read last cycle lands one slot over
        if (rvalid_q) begin
          if (act_q != alid_pkg::ACT_INSERT && raddr_q == pos_q) begin
            rd_d = alid_pkg::ValWidth'(ram_rdata);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = (act_q == alid_pkg::ACT_INSERT) ? raddr_q + AW'(1)
                                                        : raddr_q - AW'(1);
            ram_wdata = ram_rdata;
          end
        end
        if (!reading_q) begin
          state_d = alid_pkg::S_FINISH;
        end
      end

      alid_pkg::S_FINISH: begin
        // new value goes into the hole; rewriting while stalled is harmless
        if (act_q == alid_pkg::ACT_INSERT && status_q == alid_pkg::STATUS_OK) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = val_q;
        end
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = status_q;
          out_d.read_value  = rd_q;
          out_d.list_length = alid_pkg::LenWidth'(count_q);
          out_d.is_empty    = (count_q == '0);
          out_valid_d       = 1'b1;
          state_d           = alid_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = alid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alid_pkg::S_IDLE;
      count_q     <= '0;
      reading_q   <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      reading_q   <= reading_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    rd_q     <= rd_d;
    ptr_q    <= ptr_d;
    last_q   <= last_d;
    raddr_q  <= raddr_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_rvalid_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == alid_pkg::S_SHIFT))
    else $error("RAM read data arrived outside the shift loop");

endmodule
